[sv/des_block_cipher_core_defines.svh]
// Assertion macros shared by the DES core.
`ifndef DES_BLOCK_CIPHER_CORE_DEFINES_SVH
`define DES_BLOCK_CIPHER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define DES_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DES_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DES_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[sv/des_pkg.sv]
// Types, tables and permutation functions for the DES core.
package des_pkg;

    localparam int unsigned NumRounds = 16;
    localparam int unsigned BlockWidth = 64;
    localparam int unsigned HalfWidth = 28;
    localparam int unsigned SubkeyWidth = 48;

    typedef logic [BlockWidth-1:0] block_t;
    typedef logic [31:0] half_t;
    typedef logic [SubkeyWidth-1:0] subkey_t;
    typedef logic [HalfWidth-1:0] kh_t;

    typedef enum logic [0:0] {
        REG_CIPHER_KEY = 1'b0,
        REG_DECRYPT_MODE = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic valid;
        logic decrypt;
    } stage_ctl_t;

    typedef logic [6:0] tab64_t [64];

    localparam tab64_t TabIp = '{
        7'd58,7'd50,7'd42,7'd34,7'd26,7'd18,7'd10,7'd2,
        7'd60,7'd52,7'd44,7'd36,7'd28,7'd20,7'd12,7'd4,
        7'd62,7'd54,7'd46,7'd38,7'd30,7'd22,7'd14,7'd6,
        7'd64,7'd56,7'd48,7'd40,7'd32,7'd24,7'd16,7'd8,
        7'd57,7'd49,7'd41,7'd33,7'd25,7'd17,7'd9,7'd1,
        7'd59,7'd51,7'd43,7'd35,7'd27,7'd19,7'd11,7'd3,
        7'd61,7'd53,7'd45,7'd37,7'd29,7'd21,7'd13,7'd5,
        7'd63,7'd55,7'd47,7'd39,7'd31,7'd23,7'd15,7'd7};

    localparam tab64_t TabFp = '{
        7'd40,7'd8,7'd48,7'd16,7'd56,7'd24,7'd64,7'd32,
        7'd39,7'd7,7'd47,7'd15,7'd55,7'd23,7'd63,7'd31,
        7'd38,7'd6,7'd46,7'd14,7'd54,7'd22,7'd62,7'd30,
        7'd37,7'd5,7'd45,7'd13,7'd53,7'd21,7'd61,7'd29,
        7'd36,7'd4,7'd44,7'd12,7'd52,7'd20,7'd60,7'd28,
        7'd35,7'd3,7'd43,7'd11,7'd51,7'd19,7'd59,7'd27,
        7'd34,7'd2,7'd42,7'd10,7'd50,7'd18,7'd58,7'd26,
        7'd33,7'd1,7'd41,7'd9,7'd49,7'd17,7'd57,7'd25};

    typedef logic [6:0] tab56_t [56];
    localparam tab56_t TabPc1 = '{
        7'd57,7'd49,7'd41,7'd33,7'd25,7'd17,7'd9,7'd1,7'd58,7'd50,7'd42,7'd34,7'd26,7'd18,
        7'd10,7'd2,7'd59,7'd51,7'd43,7'd35,7'd27,7'd19,7'd11,7'd3,7'd60,7'd52,7'd44,7'd36,
        7'd63,7'd55,7'd47,7'd39,7'd31,7'd23,7'd15,7'd7,7'd62,7'd54,7'd46,7'd38,7'd30,7'd22,
        7'd14,7'd6,7'd61,7'd53,7'd45,7'd37,7'd29,7'd21,7'd13,7'd5,7'd28,7'd20,7'd12,7'd4};

    typedef logic [5:0] tab48_t [48];
    localparam tab48_t TabPc2 = '{
        6'd14,6'd17,6'd11,6'd24,6'd1,6'd5,6'd3,6'd28,6'd15,6'd6,6'd21,6'd10,
        6'd23,6'd19,6'd12,6'd4,6'd26,6'd8,6'd16,6'd7,6'd27,6'd20,6'd13,6'd2,
        6'd41,6'd52,6'd31,6'd37,6'd47,6'd55,6'd30,6'd40,6'd51,6'd45,6'd33,6'd48,
        6'd44,6'd49,6'd39,6'd56,6'd34,6'd53,6'd46,6'd42,6'd50,6'd36,6'd29,6'd32};

    localparam tab48_t TabExp = '{
        6'd32,6'd1,6'd2,6'd3,6'd4,6'd5,6'd4,6'd5,6'd6,6'd7,6'd8,6'd9,
        6'd8,6'd9,6'd10,6'd11,6'd12,6'd13,6'd12,6'd13,6'd14,6'd15,6'd16,6'd17,
        6'd16,6'd17,6'd18,6'd19,6'd20,6'd21,6'd20,6'd21,6'd22,6'd23,6'd24,6'd25,
        6'd24,6'd25,6'd26,6'd27,6'd28,6'd29,6'd28,6'd29,6'd30,6'd31,6'd32,6'd1};

    typedef logic [5:0] tab32_t [32];
    localparam tab32_t TabPbox = '{
        6'd16,6'd7,6'd20,6'd21,6'd29,6'd12,6'd28,6'd17,
        6'd1,6'd15,6'd23,6'd26,6'd5,6'd18,6'd31,6'd10,
        6'd2,6'd8,6'd24,6'd14,6'd32,6'd27,6'd3,6'd9,
        6'd19,6'd13,6'd30,6'd6,6'd22,6'd11,6'd4,6'd25};

    localparam logic [15:0] RotTwo = 16'b0011_1111_0111_1110;

    typedef logic [3:0] sbox_t [8][64];
    localparam sbox_t TabSbox = '{
        '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
          4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
          4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
          4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
        '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
          4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
          4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
          4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
        '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
          4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
          4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
          4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
        '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
          4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
          4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
          4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
        '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
          4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
          4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
          4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
        '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
          4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
          4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
          4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
        '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
          4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
          4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
          4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
        '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
          4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
          4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
          4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

    function automatic block_t perm_ip(input block_t src);
        block_t r;
        for (int k = 0; k < 64; k++)
        begin
            r[63-k] = src[64 - int'(TabIp[k])];
        end
        return r;
    endfunction

    function automatic block_t perm_fp(input block_t src);
        block_t r;
        for (int k = 0; k < 64; k++)
        begin
            r[63-k] = src[64 - int'(TabFp[k])];
        end
        return r;
    endfunction

    function automatic logic [55:0] perm_pc1(input block_t src);
        logic [55:0] r;
        for (int k = 0; k < 56; k++)
        begin
            r[55-k] = src[64 - int'(TabPc1[k])];
        end
        return r;
    endfunction

    function automatic subkey_t perm_pc2(input logic [55:0] src);
        subkey_t r;
        for (int k = 0; k < 48; k++)
        begin
            r[47-k] = src[56 - int'(TabPc2[k])];
        end
        return r;
    endfunction

    function automatic kh_t rotl(input kh_t v, input int unsigned rnd);
        kh_t r;
        if (RotTwo[15 - rnd])
        begin
            r = {v[HalfWidth-3:0], v[HalfWidth-1:HalfWidth-2]};
        end
        else
        begin
            r = {v[HalfWidth-2:0], v[HalfWidth-1]};
        end
        return r;
    endfunction

    function automatic half_t feistel(input half_t half, input subkey_t rk);
        subkey_t x;
        half_t s;
        half_t r;
        logic [5:0] six;
        for (int k = 0; k < 48; k++)
        begin
            x[47-k] = half[32 - int'(TabExp[k])];
        end
        x = x ^ rk;
        for (int n = 0; n < 8; n++)
        begin
            six = x[47-6*n -: 6];
            s[31-4*n -: 4] = TabSbox[n][{six[5], six[0], six[4:1]}];
        end
        for (int k = 0; k < 32; k++)
        begin
            r[31-k] = s[32 - int'(TabPbox[k])];
        end
        return r;
    endfunction

endpackage

[sv/des_key_sched.sv]
// Round subkey schedule derived from the key register.
module des_key_sched
(
    input  logic                clk,
    input  des_pkg::block_t     cipher_key,
    output des_pkg::subkey_t    subkeys [des_pkg::NumRounds]
);

    des_pkg::kh_t c_next [des_pkg::NumRounds];
    des_pkg::kh_t d_next [des_pkg::NumRounds];
    des_pkg::subkey_t subkey_reg [des_pkg::NumRounds];
    logic [55:0] cd;

    always_comb
    begin
        cd = des_pkg::perm_pc1(cipher_key);
        c_next[0] = des_pkg::rotl(cd[55:28], 0);
        d_next[0] = des_pkg::rotl(cd[27:0], 0);
        for (int r = 1; r < des_pkg::NumRounds; r++)
        begin
            c_next[r] = des_pkg::rotl(c_next[r-1], r);
            d_next[r] = des_pkg::rotl(d_next[r-1], r);
        end
    end

    // The user must change the key only while the block is idle (unenforced here), so a registered copy is safe.
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < des_pkg::NumRounds; r++)
        begin
            subkey_reg[r] <= des_pkg::perm_pc2({c_next[r], d_next[r]});
        end
    end

    assign subkeys = subkey_reg;

endmodule

[sv/des_round.sv]
// One registered Feistel round stage.
module des_round
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  des_pkg::stage_ctl_t    ctl_in,
    input  des_pkg::half_t         l_in,
    input  des_pkg::half_t         r_in,
    input  des_pkg::subkey_t       key_enc,
    input  des_pkg::subkey_t       key_dec,
    output des_pkg::stage_ctl_t    ctl_out,
    output des_pkg::half_t         l_out,
    output des_pkg::half_t         r_out
);

    des_pkg::stage_ctl_t ctl_reg;
    des_pkg::half_t l_reg;
    des_pkg::half_t r_reg;
    des_pkg::subkey_t rk;

    assign rk = ctl_in.decrypt ? key_dec : key_enc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg <= r_in;
        r_reg <= l_in ^ des_pkg::feistel(r_in, rk);
    end

    assign ctl_out = ctl_reg;
    assign l_out = l_reg;
    assign r_out = r_reg;

endmodule

[sv/des_block_cipher_core.sv]
// Top level of the pipelined DES core.
//
// Blocks enter on start with block_in; an item is taken whenever start is high and
// busy is low. busy is tied low: the core takes one item in every cycle.
// Each item passes an input register with the initial permutation, sixteen round
// stages and an output register with the final permutation, so its result shows on
// block_out with done high for one cycle.
// Throughput is one block per clock, set by the sixteen unrolled round stages.
// The user must write the key and direction via wr_en, wr_index and wr_data only
// while no item is in flight; the core does not enforce it. The round subkeys are
// registered from the key register after a key write, in time for an item taken at the next edge.
// Reset clears the key, mode and control registers to zero and empties the pipeline.
// The receiver cannot stall: done is a single-cycle strobe.
`include "des_block_cipher_core_defines.svh"
module des_block_cipher_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  des_pkg::block_t     block_in,
    output logic                done,
    output des_pkg::block_t     block_out,
    input  logic                wr_en,
    input  logic [0:0]          wr_index,
    input  des_pkg::block_t     wr_data
);

    localparam int unsigned Nr = des_pkg::NumRounds;

    des_pkg::block_t cipher_key_reg;
    logic decrypt_mode_reg;
    des_pkg::subkey_t subkeys [Nr];
    des_pkg::stage_ctl_t ctl [Nr+1];
    des_pkg::half_t lh [Nr+1];
    des_pkg::half_t rh [Nr+1];
    des_pkg::stage_ctl_t in_ctl_reg;
    des_pkg::block_t in_blk_reg;
    logic done_reg;
    des_pkg::block_t out_reg;
    logic accept;

    assign busy = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_key_reg <= '0;
            decrypt_mode_reg <= 1'b0;
            in_ctl_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                case (des_pkg::reg_index_t'(wr_index))
                    des_pkg::REG_CIPHER_KEY: cipher_key_reg <= wr_data;
                    des_pkg::REG_DECRYPT_MODE: decrypt_mode_reg <= wr_data[0];
                    default: ;
                endcase
            end
            in_ctl_reg <= '{valid: accept, decrypt: decrypt_mode_reg};
            done_reg <= ctl[Nr].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        in_blk_reg <= des_pkg::perm_ip(block_in);
        out_reg <= des_pkg::perm_fp({rh[Nr], lh[Nr]});
    end

    des_key_sched u_key (
        .clk        (clk),
        .cipher_key (cipher_key_reg),
        .subkeys    (subkeys)
    );

    assign ctl[0] = in_ctl_reg;
    assign lh[0] = in_blk_reg[63:32];
    assign rh[0] = in_blk_reg[31:0];

    for (genvar i = 0; i < Nr; i++)
    begin : g_round
        des_round u_round (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl[i]),
            .l_in    (lh[i]),
            .r_in    (rh[i]),
            .key_enc (subkeys[i]),
            .key_dec (subkeys[Nr-1-i]),
            .ctl_out (ctl[i+1]),
            .l_out   (lh[i+1]),
            .r_out   (rh[i+1])
        );
    end

    assign done = done_reg;
    assign block_out = out_reg;

    `DES_ASSERT_NEXT(a_enter, clk, rst_n, accept, in_ctl_reg.valid)
    `DES_ASSERT_NEXT(a_leave, clk, rst_n, ctl[Nr].valid, done)
    `DES_ASSERT_NEXT(a_stage, clk, rst_n, ctl[7].valid, ctl[8].valid)

endmodule
